### hdl/uuid_text_parser_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the UUID text parser.
// Every macro samples on the rising edge of clk and is disabled in reset.
// ---------------------------------------------------------------------------
`ifndef UUID_TEXT_PARSER_ASSERT_SVH
`define UUID_TEXT_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UUP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UUP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/uup_pkg.sv
// ---------------------------------------------------------------------------
// uup_pkg
// Types and constants shared by the UUID text parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package uup_pkg;

  // Parse phase, one-hot.
  typedef enum logic [3:0] {
    PH_LEAD  = 4'b0001,
    PH_DIGIT = 4'b0010,
    PH_DASH  = 4'b0100,
    PH_TRAIL = 4'b1000
  } phase_t;

  // Result status codes.
  localparam logic [1:0] ST_VALID       = 2'd0;
  localparam logic [1:0] ST_MALFORMED   = 2'd1;
  localparam logic [1:0] ST_BAD_VERSION = 2'd2;

  // Variant classes.
  localparam logic [1:0] VAR_RESERVED = 2'd0;
  localparam logic [1:0] VAR_RFC4122  = 2'd1;
  localparam logic [1:0] VAR_VENDOR   = 2'd2;

  // Digit counts at which a dash must follow, and the full digit count.
  localparam logic [5:0] DASH_AT_0    = 6'd8;
  localparam logic [5:0] DASH_AT_1    = 6'd12;
  localparam logic [5:0] DASH_AT_2    = 6'd16;
  localparam logic [5:0] DASH_AT_3    = 6'd20;
  localparam logic [5:0] DIGITS_TOTAL = 6'd32;

  // Character codes.
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Highest version nibble that is accepted.
  localparam logic [3:0] VERSION_MAX = 4'd5;

  // One input request.
  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       is_last;
  } in_t;

  // One result request.
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
    logic [3:0]  version_nibble;
    logic [1:0]  variant_class;
  } out_t;

endpackage

### hdl/uuid_text_parser.sv
// ---------------------------------------------------------------------------
// uuid_text_parser
// Streaming parser for the canonical 8-4-4-4-12 UUID text form.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_data) carries one character
//   per request. has_char marks a real character; is_last ends the string.
//   Leading and trailing whitespace is skipped, digits of either case are
//   packed most significant first into 128 bits.
//   The output channel (out_valid, out_ready, out_data) carries one result
//   per string, produced for the request with is_last set.
//   Throughput is one character per cycle unless a result is stalled;
//   each accepted character updates the parse state. The result appears
//   in the output register the cycle after the last character is accepted.
//   The output register is the only buffer: while a result waits and
//   out_ready is low, in_ready is low, so the next character waits too.
//   Taking a result and a new character happen in the same cycle.
//   Reset returns the parser to the leading whitespace phase with no
//   result pending. After each result the parse state is back at reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module uuid_text_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  uup_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output uup_pkg::out_t out_data
);

  // Whitespace: space, tab, line feed, vertical tab, form feed, return.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == uup_pkg::CH_SPACE) || (c >= uup_pkg::CH_TAB && c <= uup_pkg::CH_CR);
  endfunction

  // Returns {invalid, nibble}; invalid is set when c is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b0, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b0, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b0, d[3:0]};
    end
    return 5'b10000;
  endfunction

  uup_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]      count_r, count_nxt;
  logic [127:0]    acc_r, acc_nxt;
  logic            err_r, err_nxt;
  uup_pkg::out_t   out_r, out_nxt;
  logic            out_valid_r;
  logic            in_fire;
  logic [4:0]      hex;
  logic [5:0]      count_inc;
  logic            take_digit;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign hex       = hex_value(in_data.char_code);
  assign count_inc = count_r + 6'd1;

  // Per-character parse step.
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    acc_nxt    = acc_r;
    err_nxt    = err_r;
    take_digit = 1'b0;
    if (in_data.has_char && !err_r) begin
      unique case (phase_r)
        uup_pkg::PH_LEAD: begin
          if (!is_ws(in_data.char_code)) begin
            take_digit = 1'b1;
          end
        end
        uup_pkg::PH_DIGIT: begin
          take_digit = 1'b1;
        end
        uup_pkg::PH_DASH: begin
          if (in_data.char_code == uup_pkg::CH_DASH) begin
            phase_nxt = uup_pkg::PH_DIGIT;
          end else begin
            err_nxt = 1'b1;
          end
        end
        uup_pkg::PH_TRAIL: begin
          if (!is_ws(in_data.char_code)) begin
            err_nxt = 1'b1;
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
      // A digit shifts into the accumulator and may open a dash or the tail.
      if (take_digit) begin
        if (hex[4]) begin
          err_nxt = 1'b1;
        end else begin
          acc_nxt   = {acc_r[123:0], hex[3:0]};
          count_nxt = count_inc;
          if (count_inc >= uup_pkg::DIGITS_TOTAL) begin
            phase_nxt = uup_pkg::PH_TRAIL;
          end else if (count_inc == uup_pkg::DASH_AT_0 || count_inc == uup_pkg::DASH_AT_1 ||
                       count_inc == uup_pkg::DASH_AT_2 || count_inc == uup_pkg::DASH_AT_3) begin
            phase_nxt = uup_pkg::PH_DASH;
          end else begin
            phase_nxt = uup_pkg::PH_DIGIT;
          end
        end
      end
    end
  end

  // Result built from the state after this character.
  always_comb begin
    out_nxt = '0;
    if (err_nxt || phase_nxt != uup_pkg::PH_TRAIL) begin
      out_nxt.status = uup_pkg::ST_MALFORMED;
    end else begin
      out_nxt.uuid_high      = acc_nxt[127:64];
      out_nxt.uuid_low       = acc_nxt[63:0];
      out_nxt.version_nibble = acc_nxt[79:76];
      out_nxt.status         = uup_pkg::ST_VALID;
      if ((|acc_nxt) && (acc_nxt[79:76] == 4'd0 || acc_nxt[79:76] > uup_pkg::VERSION_MAX)) begin
        out_nxt.status = uup_pkg::ST_BAD_VERSION;
      end
      unique case (acc_nxt[63:61])
        3'b100, 3'b101: out_nxt.variant_class = uup_pkg::VAR_RFC4122;
        3'b110:         out_nxt.variant_class = uup_pkg::VAR_VENDOR;
        default:        out_nxt.variant_class = uup_pkg::VAR_RESERVED;
      endcase
    end
  end

  // Parse state registers; the end of a string returns them to reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uup_pkg::PH_LEAD;
      count_r <= '0;
      acc_r   <= '0;
      err_r   <= 1'b0;
    end else if (in_fire) begin
      if (in_data.is_last) begin
        phase_r <= uup_pkg::PH_LEAD;
        count_r <= '0;
        acc_r   <= '0;
        err_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        acc_r   <= acc_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // Output register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_data.is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.is_last) begin
      out_r <= out_nxt;
    end
  end

`include "uuid_text_parser_assert.svh"

  `UUP_ASSERT_NEXT(a_last_gives_result, in_fire && in_data.is_last, out_valid_r && phase_r == uup_pkg::PH_LEAD && count_r == 6'd0, "end of string did not produce a result or clear the state")
  `UUP_ASSERT_SAME(a_malformed_zero, out_valid_r && out_r.status == uup_pkg::ST_MALFORMED, out_r.uuid_high == 64'd0 && out_r.uuid_low == 64'd0 && out_r.version_nibble == 4'd0, "malformed result carries nonzero fields")
  `UUP_ASSERT_SAME(a_count_bound, 1'b1, count_r <= uup_pkg::DIGITS_TOTAL, "digit count exceeded the UUID length")
  `UUP_ASSERT_SAME(a_trail_full, phase_r == uup_pkg::PH_TRAIL, count_r == uup_pkg::DIGITS_TOTAL, "trailing phase reached without all digits")
  `UUP_ASSERT_SAME(a_stall_blocks, out_valid_r && !out_ready, !in_ready, "input accepted while a result is stalled")

endmodule

### verif/tb_uuid_text_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_uuid_text_parser
// Self-checking testbench for the streaming UUID text parser. Strings are
// sent one character per request. A small scoreboard class tracks the
// parse of every accepted character and queues the expected result of each
// string, then compares every result request field by field. Directed
// strings cover the corner cases, and random strings follow, most of them
// well formed. Both channels stall at random.
// ---------------------------------------------------------------------------

module tb_uuid_text_parser;

  // Character codes used to build strings.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;

  localparam int RANDOM_CHARS = 650;
  localparam int QUIET_LIMIT  = 2000;
  localparam int IDLE_PCT     = 36;

  // Tracks the parse of the current string and holds the expected results.
  class uuid_result_board;
    uup_pkg::phase_t phase;
    logic [5:0]      ndigits;
    logic [127:0]    accum;
    bit              broken;
    uup_pkg::out_t   parsed_uuids[$];
    int              errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase   = uup_pkg::PH_LEAD;
      ndigits = '0;
      accum   = '0;
      broken  = 1'b0;
    endfunction

    function bit is_space(logic [7:0] c);
      return (c == uup_pkg::CH_SPACE) || (c >= uup_pkg::CH_TAB && c <= uup_pkg::CH_CR);
    endfunction

    // Returns the digit value, or 16 for a character that is not a digit.
    function logic [4:0] nibble_of(logic [7:0] c);
      logic [7:0] d;
      d = 8'd16;
      if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
      else if (c >= CH_UP_A && c <= CH_UP_F) d = c - CH_UP_A + 8'd10;
      else if (c >= CH_LOW_A && c <= CH_LOW_F) d = c - CH_LOW_A + 8'd10;
      return d[4:0];
    endfunction

    function void parse_char(logic [7:0] c);
      logic [4:0] nib;
      if (broken) return;
      if (phase == uup_pkg::PH_LEAD) begin
        if (is_space(c)) return;
        phase = uup_pkg::PH_DIGIT;
      end
      case (phase)
        uup_pkg::PH_DIGIT: begin
          nib = nibble_of(c);
          if (nib[4]) begin
            broken = 1'b1;
          end else begin
            accum   = {accum[123:0], nib[3:0]};
            ndigits = ndigits + 6'd1;
            if (ndigits >= uup_pkg::DIGITS_TOTAL)
              phase = uup_pkg::PH_TRAIL;
            else if (ndigits == uup_pkg::DASH_AT_0 || ndigits == uup_pkg::DASH_AT_1 ||
                     ndigits == uup_pkg::DASH_AT_2 || ndigits == uup_pkg::DASH_AT_3)
              phase = uup_pkg::PH_DASH;
          end
        end
        uup_pkg::PH_DASH: begin
          if (c == uup_pkg::CH_DASH) phase = uup_pkg::PH_DIGIT;
          else broken = 1'b1;
        end
        default: begin
          if (!is_space(c)) broken = 1'b1;
        end
      endcase
    endfunction

    // Notes one accepted input request; the last one of a string queues a result.
    function void note_char(uup_pkg::in_t req);
      uup_pkg::out_t res;
      if (req.has_char) parse_char(req.char_code);
      if (!req.is_last) return;
      res = '0;
      if (broken || phase != uup_pkg::PH_TRAIL) begin
        res.status = uup_pkg::ST_MALFORMED;
      end else begin
        res.uuid_high      = accum[127:64];
        res.uuid_low       = accum[63:0];
        res.version_nibble = accum[79:76];
        if (accum != '0 && (res.version_nibble == 4'd0 ||
                            res.version_nibble > uup_pkg::VERSION_MAX))
          res.status = uup_pkg::ST_BAD_VERSION;
        else
          res.status = uup_pkg::ST_VALID;
        case (accum[63:61])
          3'b100, 3'b101: res.variant_class = uup_pkg::VAR_RFC4122;
          3'b110:         res.variant_class = uup_pkg::VAR_VENDOR;
          default:        res.variant_class = uup_pkg::VAR_RESERVED;
        endcase
      end
      parsed_uuids.push_back(res);
      restart();
    endfunction

    // Compares one accepted result request with the oldest expected one.
    function void check_parse(uup_pkg::out_t got);
      uup_pkg::out_t want;
      if (parsed_uuids.size() == 0) begin
        $error("unexpected result: status %0d", got.status);
        errors++;
        return;
      end
      want = parsed_uuids.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.uuid_high !== want.uuid_high) begin
        $error("uuid_high: expected %h, got %h", want.uuid_high, got.uuid_high);
        errors++;
      end
      if (got.uuid_low !== want.uuid_low) begin
        $error("uuid_low: expected %h, got %h", want.uuid_low, got.uuid_low);
        errors++;
      end
      if (got.version_nibble !== want.version_nibble) begin
        $error("version_nibble: expected %0d, got %0d",
               want.version_nibble, got.version_nibble);
        errors++;
      end
      if (got.variant_class !== want.variant_class) begin
        $error("variant_class: expected %0d, got %0d",
               want.variant_class, got.variant_class);
        errors++;
      end
    endfunction

    function int pending();
      return parsed_uuids.size();
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  uup_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready = 1'b0;
  uup_pkg::out_t out_data;

  uuid_result_board board;
  uup_pkg::in_t     text_q[$];
  int               chars_sent;
  int               quiet_cycles = 0;
  int               idle_in_pct  = IDLE_PCT;
  int               idle_out_pct = IDLE_PCT;

  uuid_text_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The result side stalls at random.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= idle_out_pct);
  end

  // Monitor both channels and watch for a stalled run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_char(in_data);
      if (out_valid && out_ready) board.check_parse(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("[uuid_text_parser] ERROR");
          $finish;
        end
      end
    end
  end

  function automatic uup_pkg::in_t make_item(logic [7:0] c, logic has, logic last);
    uup_pkg::in_t item;
    item.char_code = c;
    item.has_char  = has;
    item.is_last   = last;
    return item;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 4'd10) return CH_ZERO + v;
    return (upper ? CH_UP_A : CH_LOW_A) + v - 8'd10;
  endfunction

  function automatic logic [7:0] pick_space();
    int k;
    k = $urandom_range(5);
    return (k == 5) ? uup_pkg::CH_SPACE : uup_pkg::CH_TAB + k[7:0];
  endfunction

  // Random byte, biased toward characters the parser cares about.
  function automatic logic [7:0] pick_noise();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(255));
      1:       return hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
      2:       return uup_pkg::CH_DASH;
      default: return pick_space();
    endcase
  endfunction

  task automatic add_char(logic [7:0] c);
    text_q.push_back(make_item(c, 1'b1, 1'b0));
  endtask

  task automatic add_string(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  // Canonical 8-4-4-4-12 text of a 128-bit value.
  task automatic add_uuid(logic [127:0] v, bit mixed_case);
    bit upper;
    upper = 1'($urandom_range(1));
    for (int i = 0; i < 32; i++) begin
      if (i == 8 || i == 12 || i == 16 || i == 20) add_char(uup_pkg::CH_DASH);
      if (mixed_case) upper = 1'($urandom_range(1));
      add_char(hex_char(v[127 - 4 * i -: 4], upper));
    end
  endtask

  // Drives one input request and waits until it is accepted.
  task automatic send_item(uup_pkg::in_t item);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.has_char) chars_sent++;
    @(negedge clk);
  endtask

  // Ends the built string on its last character or with an end marker,
  // then sends it.
  task automatic send_text(bit with_marker);
    uup_pkg::in_t item;
    if (with_marker || text_q.size() == 0) begin
      text_q.push_back(make_item(8'($urandom_range(255)), 1'b0, 1'b1));
    end else begin
      item = text_q.pop_back();
      item.is_last = 1'b1;
      text_q.push_back(item);
    end
    foreach (text_q[i]) send_item(text_q[i]);
    text_q.delete();
  endtask

  initial begin
    logic [127:0] v;
    byte unsigned odd_codes[$];
    int           text_n;
    int           n;
    int           pos;

    odd_codes = {8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF};
    board    = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Nil UUID is valid, and all ones has a bad version nibble.
    add_string("00000000-0000-0000-0000-000000000000");
    send_text(1'b0);
    add_string("FFFFFFFF-FFFF-FFFF-FFFF-FFFFFFFFFFFF");
    send_text(1'b1);

    // Every whitespace code before, return and space after, with a filler request inside.
    add_char(uup_pkg::CH_SPACE);
    for (int k = 0; k < 5; k++) add_char(uup_pkg::CH_TAB + k[7:0]);
    add_string("123e4567-e89b-42d3");
    text_q.push_back(make_item(8'hA5, 1'b0, 1'b0));
    add_string("-a456-426614174000");
    add_char(uup_pkg::CH_CR);
    add_char(uup_pkg::CH_SPACE);
    send_text(1'b1);

    // Version nibbles 0 to 6 across all variant classes.
    for (int k = 0; k < 7; k++) begin
      v = 128'h0123_4567_89ab_0cde_0f12_3456_789a_bcde;
      v[79:76] = k[3:0];
      case (k % 4)
        0: v[63:60] = 4'h2;
        1: v[63:60] = 4'h9;
        2: v[63:60] = 4'hd;
        default: v[63:60] = 4'hf;
      endcase
      add_uuid(v, k[0]);
      send_text(k[1]);
    end

    // Empty, whitespace only and short strings.
    send_text(1'b1);
    add_string("   ");
    send_text(1'b1);
    add_string("12345678-1234");
    send_text(1'b0);

    // Missing dash, extra digit, trailing garbage, dash first, double dash,
    // and a space between digits.
    add_string("123456781234-5678-9abc-def012345678");
    send_text(1'b1);
    add_string("12345678-1234-5678-9abc-def0123456789");
    send_text(1'b0);
    add_string("12345678-1234-4678-9abc-def012345678 x");
    send_text(1'b1);
    add_string("-12345678-1234-4678-9abc-def012345678");
    send_text(1'b0);
    add_string("12345678--1234-4678-9abc-def012345678");
    send_text(1'b1);
    add_string("1234 5678-1234-4678-9abc-def012345678");
    send_text(1'b0);

    // Codes just outside the digit ranges, NUL and a high code; the rest
    // of the string is ignored after the error.
    foreach (odd_codes[k]) begin
      add_string("1234567");
      add_char(odd_codes[k]);
      add_string("-1234-4678-9abc-def012345678");
      send_text(k[0]);
    end

    // Random strings, mostly well formed.
    chars_sent = 0;
    text_n = 0;
    while (chars_sent < RANDOM_CHARS) begin
      // A stretch of strings with no stalls on either side.
      idle_in_pct  = (text_n >= 5 && text_n < 15) ? 0 : IDLE_PCT;
      idle_out_pct = idle_in_pct;
      n = $urandom_range(99);
      if (n < 85) begin
        v = {$urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(99) < 3) v = '0;
        else if ($urandom_range(99) < 60) v[79:76] = 4'($urandom_range(5, 1));
        repeat ($urandom_range(3)) add_char(pick_space());
        add_uuid(v, 1'($urandom_range(1)));
        repeat ($urandom_range(3)) add_char(pick_space());
        // Filler requests between characters.
        repeat ($urandom_range(2)) begin
          pos = $urandom_range(text_q.size());
          text_q.insert(pos, make_item(8'($urandom_range(255)), 1'b0, 1'b0));
        end
        if (n < 70) begin
          // Break one spot in some of the well-formed strings.
          if ($urandom_range(99) < 25) begin
            pos = $urandom_range(text_q.size() - 1);
            case ($urandom_range(2))
              0: text_q[pos] = make_item(pick_noise(), 1'b1, 1'b0);
              1: text_q.delete(pos);
              default: text_q.insert(pos, make_item(pick_noise(), 1'b1, 1'b0));
            endcase
          end
        end else begin
          pos = $urandom_range(text_q.size());
          while (text_q.size() > pos) void'(text_q.pop_back());
        end
      end else begin
        repeat ($urandom_range(40)) add_char(pick_noise());
      end
      send_text(1'($urandom_range(1)));
      text_n++;
    end

    // Drain the outstanding results, then allow the pipeline to settle.
    in_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[uuid_text_parser] OK");
    end else begin
      $display("[uuid_text_parser] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/uup_pkg.sv
hdl/uuid_text_parser.sv
verif/tb_uuid_text_parser.sv
